[hdl/two_pkg.sv]
package two_pkg;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegWheelRadius   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegForwardOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSideOffset    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartX        = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStartY        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTargetX       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTargetY       = 3'd6;

  localparam logic [31:0] DegQ32     = 32'd74961321;
  localparam logic [31:0] InvPiQ30   = 32'd341782638;
  localparam logic [31:0] CordicGain = 32'd652032874;

  typedef struct packed {
    logic signed [31:0] forward_count;
    logic signed [31:0] sideways_count;
    logic [15:0]        imu_heading;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_angle;
    logic [31:0]        goal_distance;
  } pose_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'h20000000;
      5'd1:  atan_turn = 32'h12E4051D;
      5'd2:  atan_turn = 32'h09FB385B;
      5'd3:  atan_turn = 32'h051111D4;
      5'd4:  atan_turn = 32'h028B0D43;
      5'd5:  atan_turn = 32'h0145D7E1;
      5'd6:  atan_turn = 32'h00A2F61E;
      5'd7:  atan_turn = 32'h00517C55;
      5'd8:  atan_turn = 32'h0028BE53;
      5'd9:  atan_turn = 32'h00145F2F;
      5'd10: atan_turn = 32'h000A2F98;
      5'd11: atan_turn = 32'h000517CC;
      5'd12: atan_turn = 32'h00028BE6;
      5'd13: atan_turn = 32'h000145F3;
      5'd14: atan_turn = 32'h0000A2FA;
      5'd15: atan_turn = 32'h0000517D;
      5'd16: atan_turn = 32'h000028BE;
      5'd17: atan_turn = 32'h0000145F;
      5'd18: atan_turn = 32'h00000A30;
      5'd19: atan_turn = 32'h00000518;
      5'd20: atan_turn = 32'h0000028C;
      5'd21: atan_turn = 32'h00000146;
      5'd22: atan_turn = 32'h000000A3;
      5'd23: atan_turn = 32'h00000051;
      default: atan_turn = 32'h0;
    endcase
  endfunction

endpackage

[hdl/two_tick_if.sv]
interface two_tick_if;
  import two_pkg::*;
  logic  valid;
  logic  ready;
  tick_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/two_pose_if.sv]
interface two_pose_if;
  import two_pkg::*;
  logic  valid;
  logic  ready;
  pose_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/two_cfg_if.sv]
interface two_cfg_if;
  import two_pkg::*;
  logic valid;
  logic ready;
  cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/tracking_wheel_odometry.sv]
// Tracking-wheel odometry. Each tick beat (two encoder counts in degrees and
// a clockwise IMU heading) updates the Q16.16 pose and yields one result beat
// with pose, orientation and distance to the goal point. The block works on
// one tick at a time with a 32x32 multiplier shared by the wheel travel, chord,
// rotation and distance products, one shift-add CORDIC rotator, a restoring
// divider and a bit-pair square root, all run by one sequencer. A turning
// tick runs each wheel travel, a first CORDIC pass, the division, the chord,
// a second CORDIC pass, the rotation, the squared goal offset and the square
// root, in that order. A straight tick skips the first CORDIC, the division
// and the chord. A saturated goal distance skips the square root.
// The tick port is ready again in the cycle after the result beat leaves, so
// a new tick is taken only once the last result has gone, later while the
// result side stalls. Register writes are taken only between ticks;
// writing a start coordinate also reloads that pose accumulator.
module tracking_wheel_odometry #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic     clk,
  input logic     rst,
  two_cfg_if.sink  cfg,
  two_tick_if.sink tick,
  two_pose_if.source pose
);
  import two_pkg::*;

  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TRAVL = 14'b00000000000010,
    S_TRAVS = 14'b00000000000100,
    S_COR1  = 14'b00000000001000,
    S_DIV   = 14'b00000000010000,
    S_CHRD  = 14'b00000000100000,
    S_COR2  = 14'b00000001000000,
    S_ROT   = 14'b00000010000000,
    S_SQ    = 14'b00000100000000,
    S_SQRT  = 14'b00001000000000,
    S_OUT   = 14'b00010000000000,
    S_MULA  = 14'b00100000000000,
    S_MULB  = 14'b01000000000000,
    S_ACC   = 14'b10000000000000
  } state_t;

  state_t state;

  logic [21:0] wheel_rad;
  logic [23:0] forward_wheel_offset, side_wheel_offset;
  logic signed [31:0] target_x, target_y;
  logic [31:0] prev_forward, prev_sideways;
  logic [ANGLE_BITS-1:0] prev_angle;
  logic signed [31:0] acc_x, acc_y;

  tick_t in_q;
  logic [ANGLE_BITS-1:0] orient;
  logic signed [ANGLE_BITS-1:0] dth;
  logic signed [31:0] d_l, d_s, l_x, l_y;
  logic signed [33:0] sh, cx, cy;
  logic signed [33:0] s_rot, c_rot;
  logic signed [32:0] cz;
  logic cflip;
  logic [StepW-1:0] cstep;
  logic [6:0] cnt;
  logic [2:0] phase;
  logic [31:0] r_q;
  logic [63:0] dv_rem, dv_quo;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [63:0] sq_a;
  logic signed [67:0] sum_a;
  logic [55:0] t_mag;
  logic t_neg;
  pose_t out_q;

  // Shared multiplier: 34x34 signed operands split into a 32-bit unsigned
  // magnitude product on which sign is reapplied.
  logic signed [33:0] mul_a, mul_b;
  logic [31:0] ma, mb;
  logic neg;
  logic [63:0] mprod;
  logic signed [65:0] mul_p;

  assign cfg.ready  = (state == S_IDLE);
  assign tick.ready = (state == S_IDLE);
  assign pose.valid = (state == S_OUT);
  assign pose.payload = out_q;

  always_comb begin
    logic [33:0] aa, bb;
    aa = mul_a[33] ? 34'(-mul_a) : 34'(mul_a);
    bb = mul_b[33] ? 34'(-mul_b) : 34'(mul_b);
    ma = aa[31:0];
    mb = bb[31:0];
    neg = mul_a[33] ^ mul_b[33];
    mprod = 64'(ma) * 64'(mb);
    mul_p = neg ? -$signed({2'b00, mprod}) : $signed({2'b00, mprod});
  end

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) sat32 = 32'h7FFFFFFF;
    else if (v < -68'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v + 68'sd536870912;
    rnd30 = t >>> 30;
  endfunction

  // Wheel travel from the registered product magnitude and its sign.
  function automatic logic signed [31:0] travel(input logic neg_p,
                                                input logic [23:0] hi,
                                                input logic [63:0] lo_part);
    logic [63:0] r;
    r = 64'(hi) * 64'(DegQ32) + 64'(lo_part[63:32]);
    if (neg_p) travel = (r > 64'h80000000) ? 32'h80000000 : 32'(-r);
    else travel = (r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
  endfunction

  logic signed [31:0] cnt_diff;
  logic signed [55:0] tp;
  logic [55:0] tm;
  logic signed [31:0] trav;
  always_comb begin
    cnt_diff = (state == S_TRAVL) ? 32'(in_q.forward_count - prev_forward)
                                  : 32'(in_q.sideways_count - prev_sideways);
    tp = 56'(cnt_diff) * $signed({34'd0, wheel_rad});
    tm = tp[55] ? 56'(-tp) : 56'(tp);
    trav = travel(t_neg, t_mag[55:32], mprod + 64'h80000000);
  end

  logic signed [67:0] rot_r;
  always_comb rot_r = rnd30((phase == 3'd1) ? sum_a - 68'(mul_p) : sum_a + 68'(mul_p));

  logic [31:0] half32, avg32, c_ang;
  always_comb begin
    half32 = 32'(dth) << (31 - ANGLE_BITS);
    avg32  = (32'(orient) << (32 - ANGLE_BITS)) - half32;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TRAVL, S_TRAVS: begin
        mul_a = {2'b00, t_mag[31:0]};
        mul_b = {2'b00, DegQ32};
      end
      S_DIV: begin
        mul_a = sh[33] ? 34'(-sh) : sh;
        mul_b = {2'b00, InvPiQ30};
      end
      S_CHRD: begin
        case (phase)
          3'd0: begin mul_a = {2'b00, r_q}; mul_b = 34'(d_s); end
          3'd1: begin mul_a = sh <<< 1; mul_b = {10'd0, side_wheel_offset}; end
          3'd2: begin mul_a = {2'b00, r_q}; mul_b = 34'(d_l); end
          default: begin mul_a = sh <<< 1; mul_b = {10'd0, forward_wheel_offset}; end
        endcase
      end
      S_ROT: begin
        case (phase)
          3'd0: begin mul_a = 34'(l_y); mul_b = c_rot; end
          3'd1: begin mul_a = 34'(l_x); mul_b = s_rot; end
          3'd2: begin mul_a = 34'(l_y); mul_b = s_rot; end
          default: begin mul_a = 34'(l_x); mul_b = c_rot; end
        endcase
      end
      S_SQ: begin
        mul_a = (phase == 3'd0) ? 34'(target_x) - 34'(acc_x)
                                : 34'(target_y) - 34'(acc_y);
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  // A straight tick goes directly to the rotation by the mid-step angle.
  always_comb c_ang = (dth == '0) ? avg32 : half32;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel_rad <= 22'd90374;
      forward_wheel_offset <= 24'd447840;
      side_wheel_offset <= 24'd383386;
      target_x <= 32'sd990904;
      target_y <= 32'sd8383365;
      acc_x <= 32'sd3702784;
      acc_y <= 32'sd557056;
      prev_forward <= '0;
      prev_sideways <= '0;
      prev_angle <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.payload.index)
          RegWheelRadius:   wheel_rad <= cfg.payload.data[21:0];
          RegForwardOffset: forward_wheel_offset <= cfg.payload.data[23:0];
          RegSideOffset:    side_wheel_offset <= cfg.payload.data[23:0];
          RegStartX:        acc_x <= cfg.payload.data;
          RegStartY:        acc_y <= cfg.payload.data;
          RegTargetX:       target_x <= cfg.payload.data;
          RegTargetY:       target_y <= cfg.payload.data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            in_q <= tick.payload;
            orient <= ANGLE_BITS'(-tick.payload.imu_heading);
            phase <= '0;
            state <= S_TRAVL;
          end
        end
        S_TRAVL: begin
          if (phase == 3'd0) begin
            t_mag <= tm;
            t_neg <= tp[55];
            dth <= $signed(orient - prev_angle);
            phase <= 3'd1;
          end else begin
            d_l <= trav;
            phase <= '0;
            state <= S_TRAVS;
          end
        end
        S_TRAVS: begin
          if (phase == 3'd0) begin
            t_mag <= tm;
            t_neg <= tp[55];
            phase <= 3'd1;
          end else begin
            d_s <= trav;
            cstep <= '0;
            phase <= '0;
            if (dth == '0) begin
              l_x <= trav;
              l_y <= d_l;
              state <= S_COR2;
            end else begin
              state <= S_COR1;
            end
            cflip <= (c_ang[31:30] == 2'b01) || (c_ang[31:30] == 2'b10);
            cz <= 33'($signed(c_ang - (((c_ang[31:30] == 2'b01) ||
                  (c_ang[31:30] == 2'b10)) ? 32'h80000000 : 32'h0)));
            cx <= 34'(CordicGain);
            cy <= '0;
            cnt <= '0;
          end
        end
        S_COR1, S_COR2: begin
          if (cstep == StepW'(CORDIC_STEPS)) begin
            if (state == S_COR1) begin
              sh <= cflip ? -cy : cy;
              state <= S_DIV;
              cnt <= '0;
              phase <= '0;
            end else begin
              s_rot <= cflip ? -cy : cy;
              c_rot <= cflip ? -cx : cx;
              state <= S_ROT;
              phase <= '0;
            end
          end else begin
            if (!cz[32]) begin
              cx <= cx - (cy >>> cstep);
              cy <= cy + (cx >>> cstep);
              cz <= cz - $signed({1'b0, atan_turn(5'(cstep))});
            end else begin
              cx <= cx + (cy >>> cstep);
              cy <= cy - (cx >>> cstep);
              cz <= cz + $signed({1'b0, atan_turn(5'(cstep))});
            end
            cstep <= cstep + 1'b1;
          end
        end
        S_DIV: begin
          // Restoring division of |sin|*InvPi by |dth|, one bit per cycle.
          if (cnt == 7'd0) begin
            dv_quo <= mprod;
            dv_rem <= '0;
            cnt <= 7'd1;
          end else if (cnt <= 7'd64) begin
            logic [64:0] rr;
            logic [63:0] dm;
            dm = 64'({1'b0, dth[ANGLE_BITS-1] ? -dth : dth});
            rr = {dv_rem, dv_quo[63]};
            if (rr >= 65'(dm)) begin
              dv_rem <= 64'(rr - 65'(dm));
              dv_quo <= {dv_quo[62:0], 1'b1};
            end else begin
              dv_rem <= rr[63:0];
              dv_quo <= {dv_quo[62:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
          end else begin
            logic [63:0] rq;
            rq = (dv_quo + (64'd1 << (29 - ANGLE_BITS))) >> (30 - ANGLE_BITS);
            r_q <= rq[31:0];
            phase <= '0;
            state <= S_CHRD;
          end
        end
        S_CHRD: begin
          phase <= phase + 1'b1;
          case (phase)
            3'd0: sum_a <= rnd30(68'(mul_p));
            3'd1: l_x <= sat32(sum_a + rnd30(68'(mul_p)));
            3'd2: sum_a <= rnd30(68'(mul_p));
            default: begin
              l_y <= sat32(sum_a - rnd30(68'(mul_p)));
              cflip <= (avg32[31:30] == 2'b01) || (avg32[31:30] == 2'b10);
              cz <= 33'($signed(avg32 - (((avg32[31:30] == 2'b01) ||
                    (avg32[31:30] == 2'b10)) ? 32'h80000000 : 32'h0)));
              cx <= 34'(CordicGain);
              cy <= '0;
              cstep <= '0;
              state <= S_COR2;
            end
          endcase
        end
        S_ROT: begin
          phase <= phase + 1'b1;
          case (phase)
            3'd0: sum_a <= 68'(mul_p);
            3'd1: begin
              acc_x <= acc_x + rot_r[31:0];
            end
            3'd2: sum_a <= 68'(mul_p);
            default: begin
              acc_y <= acc_y + rot_r[31:0];
              prev_forward <= in_q.forward_count;
              prev_sideways <= in_q.sideways_count;
              prev_angle <= orient;
              phase <= '0;
              state <= S_SQ;
            end
          endcase
        end
        S_SQ: begin
          phase <= phase + 1'b1;
          if (phase == 3'd0) sq_a <= mprod;
          else begin
            logic [64:0] s;
            s = 65'(sq_a) + 65'(mprod);
            sq_v <= s[63:0];
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            cnt <= '0;
            out_q.pose_x <= acc_x;
            out_q.pose_y <= acc_y;
            out_q.pose_angle <= 16'(orient);
            if (s[64]) begin
              out_q.goal_distance <= 32'hFFFFFFFF;
              state <= S_OUT;
            end else state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_bit == '0) begin
            out_q.goal_distance <= sq_res[31:0];
            state <= S_OUT;
          end else begin
            if (sq_v >= sq_res + sq_bit) begin
              sq_v <= sq_v - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else sq_res <= sq_res >> 1;
            sq_bit <= sq_bit >> 2;
          end
        end
        S_OUT: if (pose.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import two_pkg::*;

  localparam int NumRandom   = 1200;
  localparam int StallLimit  = 20000;
  localparam int SettleTicks = 300;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // Configuration copy kept by the testbench
  typedef struct {
    logic [21:0] radius;
    logic [23:0] fwd_off;
    logic [23:0] side_off;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
  } odo_cfg_t;

  class pose_scoreboard;
    odo_cfg_t   cfg;
    logic [31:0] last_fwd, last_side, pos_x, pos_y;
    logic [15:0] last_angle;
    pose_t       pending[$];
    int          mismatches;
    int          checked;

    function void clear(logic [31:0] sx, logic [31:0] sy);
      last_fwd = '0;
      last_side = '0;
      last_angle = '0;
      pos_x = sx;
      pos_y = sy;
    endfunction

    function automatic longint round30(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic longint travel(logic [31:0] diff);
      longint p;
      logic [63:0] m, r;
      p = longint'($signed(diff)) * longint'({42'd0, cfg.radius});
      m = (p < 0) ? 64'(-p) : 64'(p);
      r = (m >> 32) * 64'(DegQ32) + (((m & 64'hFFFF_FFFF) * 64'(DegQ32) + 64'h8000_0000) >> 32);
      if (p < 0) return (r > 64'd2147483648) ? -64'sd2147483648 : -longint'(r);
      return (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
    endfunction

    // Shift-add rotation on a 32-bit turn fraction; results are Q2.30.
    function automatic void sin_cos(logic [31:0] a, output longint sn, output longint cs);
      bit flip;
      longint x, y, z, t;
      flip = 0;
      x = longint'(CordicGain);
      y = 0;
      if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
        a = a - 32'h8000_0000;
        flip = 1;
      end
      z = longint'($signed(a));
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'({32'd0, atan_turn(5'(i))});
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'({32'd0, atan_turn(5'(i))});
        end
        x = t;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function automatic logic [31:0] root64(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    function automatic logic [31:0] distance();
      longint dx, dy;
      logic [63:0] mx, my, a, s;
      dx = longint'($signed(cfg.tgt_x)) - longint'($signed(pos_x));
      dy = longint'($signed(cfg.tgt_y)) - longint'($signed(pos_y));
      mx = (dx < 0) ? 64'(-dx) : 64'(dx);
      my = (dy < 0) ? 64'(-dy) : 64'(dy);
      a = mx * mx;
      s = a + my * my;
      if (s < a) return 32'hFFFF_FFFF;
      return root64(s);
    endfunction

    function void note_tick(tick_t t);
      longint dl, ds, dth, lx, ly, sn, co, sh, ch, r, gx, gy;
      logic [15:0] orient, raw;
      logic [31:0] half32, avg32;
      logic [63:0] sm, dm;
      pose_t e;
      dl = travel(t.forward_count - last_fwd);
      ds = travel(t.sideways_count - last_side);
      orient = 16'(0) - t.imu_heading;
      raw = orient - last_angle;
      dth = raw[15] ? longint'(raw) - 65536 : longint'(raw);
      half32 = 32'(dth) << 15;
      avg32 = {orient, 16'd0} - half32;
      if (dth == 0) begin
        lx = ds;
        ly = dl;
      end else begin
        sin_cos(half32, sh, ch);
        sm = (sh < 0) ? 64'(-sh) : 64'(sh);
        dm = (dth < 0) ? 64'(-dth) : 64'(dth);
        r = longint'(((sm * 64'(InvPiQ30)) / dm + (64'd1 << 13)) >> 14);
        lx = clamp32(round30(r * ds) + round30(2 * sh * longint'({40'd0, cfg.side_off})));
        ly = clamp32(round30(r * dl) - round30(2 * sh * longint'({40'd0, cfg.fwd_off})));
      end
      sin_cos(avg32, sn, co);
      gx = round30(ly * co - lx * sn);
      gy = round30(ly * sn + lx * co);
      last_fwd = t.forward_count;
      last_side = t.sideways_count;
      last_angle = orient;
      pos_x = pos_x + gx[31:0];
      pos_y = pos_y + gy[31:0];
      e.pose_x = pos_x;
      e.pose_y = pos_y;
      e.pose_angle = orient;
      e.goal_distance = distance();
      pending.push_back(e);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose beat %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.pose_x !== e.pose_x || got.pose_y !== e.pose_y ||
          got.pose_angle !== e.pose_angle || got.goal_distance !== e.goal_distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pose mismatch: exp x=%0h y=%0h a=%0h d=%0h got x=%0h y=%0h a=%0h d=%0h",
                   e.pose_x, e.pose_y, e.pose_angle, e.goal_distance,
                   got.pose_x, got.pose_y, got.pose_angle, got.goal_distance);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  two_cfg_if  cfg_bus();
  two_tick_if tick_bus();
  two_pose_if pose_bus();

  tracking_wheel_odometry dut (
    .clk(clk), .rst(rst), .cfg(cfg_bus.sink), .tick(tick_bus.sink), .pose(pose_bus.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pose_scoreboard sb;
  bit calm;
  int quiet_cycles;
  logic [31:0] cur_fwd, cur_side;
  logic [15:0] cur_head;

  initial begin
    cfg_bus.valid = 0;
    cfg_bus.payload = '0;
    tick_bus.valid = 0;
    tick_bus.payload = '0;
    pose_bus.ready = 0;
  end

  // Result side: random stalls except during the calm stretch.
  always @(posedge clk) begin
    if (!rst && pose_bus.valid && pose_bus.ready) sb.check_pose(pose_bus.payload);
    pose_bus.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if ((tick_bus.valid && tick_bus.ready) || (pose_bus.valid && pose_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  // Valid stays up into the next write; the first tick after a write drops it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_bus.valid <= 1;
    cfg_bus.payload <= '{index: idx, data: data};
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      RegWheelRadius:   sb.cfg.radius = data[21:0];
      RegForwardOffset: sb.cfg.fwd_off = data[23:0];
      RegSideOffset:    sb.cfg.side_off = data[23:0];
      RegStartX:        sb.pos_x = data;
      RegStartY:        sb.pos_y = data;
      RegTargetX:       sb.cfg.tgt_x = data;
      RegTargetY:       sb.cfg.tgt_y = data;
      default: ;
    endcase
  endtask

  // Valid stays up into the next beat unless an idle cycle comes first;
  // drain() drops it after the last beat.
  task automatic send_tick(logic [31:0] f, logic [31:0] s, logic [15:0] h);
    tick_t t;
    cfg_bus.valid <= 0;
    while (!calm && $urandom_range(99) < 17) begin
      tick_bus.valid <= 0;
      @(posedge clk);
    end
    t.forward_count = f;
    t.sideways_count = s;
    t.imu_heading = h;
    tick_bus.valid <= 1;
    tick_bus.payload <= t;
    do @(posedge clk); while (!tick_bus.ready);
    sb.note_tick(t);
    cur_fwd = f;
    cur_side = s;
    cur_head = h;
  endtask

  task automatic drain();
    tick_bus.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  // Mostly realistic motion: small count steps and heading turns, with some wild jumps.
  task automatic random_ticks(int n);
    logic [31:0] f, s;
    logic [15:0] h;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      case ($urandom_range(9))
        0: begin f = $urandom; s = $urandom; h = $urandom; end
        1: begin f = cur_fwd + $urandom_range(40) - 20; s = cur_side; h = cur_head; end
        2: begin f = cur_fwd; s = cur_side; h = cur_head + 16'h8000; end
        default: begin
          f = cur_fwd + $urandom_range(2000) - 1000;
          s = cur_side + $urandom_range(600) - 300;
          h = cur_head + 16'($urandom_range(4000)) - 16'd2000;
        end
      endcase
      send_tick(f, s, h);
    end
    calm = 0;
  endtask

  initial begin
    sb = new();
    sb.cfg = '{radius: 22'd90374, fwd_off: 24'd447840, side_off: 24'd383386,
               tgt_x: 32'd990904, tgt_y: 32'd8383365};
    sb.clear(32'd3702784, 32'd557056);
    calm = 0;
    quiet_cycles = 0;
    cur_fwd = 0;
    cur_side = 0;
    cur_head = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: first tick against zero history, straight travel, half turns, extremes.
    send_tick(32'd360, 32'd0, 16'd0);
    send_tick(32'd720, 32'd90, 16'd0);
    send_tick(32'd720, 32'd90, 16'h8000);
    send_tick(32'd720, 32'd90, 16'h0000);
    send_tick(32'd800, 32'd50, 16'h4000);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'h0001);
    send_tick(32'hFFFF_FFFF, 32'h0000_0000, 16'h7FFF);
    send_tick(32'h0000_0000, 32'hFFFF_FFFF, 16'h8001);
    send_tick(32'h0000_0010, 32'h0000_0010, 16'h8001);
    drain();

    write_reg(RegWheelRadius, 32'h003F_FFFF);
    write_reg(RegForwardOffset, 32'h00FF_FFFF);
    write_reg(RegSideOffset, 32'h00FF_FFFF);
    write_reg(RegStartX, 32'h7FFF_FFFF);
    write_reg(RegStartY, 32'h8000_0000);
    write_reg(RegTargetX, 32'h8000_0000);
    write_reg(RegTargetY, 32'h7FFF_FFFF);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_tick(32'h8000_1000, 32'h7FFF_F000, 16'h0123);
    drain();

    write_reg(RegWheelRadius, 32'd0);
    write_reg(RegForwardOffset, 32'd0);
    write_reg(RegSideOffset, 32'd0);
    write_reg(RegStartX, 32'd0);
    write_reg(RegStartY, 32'd0);
    write_reg(RegTargetX, 32'd0);
    write_reg(RegTargetY, 32'd0);
    send_tick(32'h1234_5678, 32'h8765_4321, 16'h5555);
    send_tick(32'h0, 32'h0, 16'hAAAA);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(RegWheelRadius, (phase == 3) ? $urandom : $urandom_range(200000, 40000));
      write_reg(RegForwardOffset, (phase == 3) ? $urandom : $urandom_range(900000));
      write_reg(RegSideOffset, (phase == 3) ? $urandom : $urandom_range(900000));
      write_reg(RegStartX, $urandom_range(20000000) - 10000000);
      write_reg(RegStartY, $urandom_range(20000000) - 10000000);
      write_reg(RegTargetX, (phase == 2) ? $urandom : $urandom_range(20000000) - 10000000);
      write_reg(RegTargetY, (phase == 2) ? $urandom : $urandom_range(20000000) - 10000000);
      random_ticks(NumRandom / 4);
      drain();
    end

    $display("covered %0d pose beats over directed extremes and four register settings",
             sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d poses outstanding", sb.mismatches, sb.pending.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
